// File: rtl/gcsa_pkg.sv
// ----------------------------------------------------------------------------
// gcsa_pkg
// Shared constants of the gaussian chi-square accumulator.
// ----------------------------------------------------------------------------
package gcsa_pkg;

	localparam int ANGLE_W = 32;
	localparam int VALUE_W = 32;
	localparam int SIGMA_W = 20;
	localparam int SUM_W   = 48;
	localparam int CNT_W   = 16;
	localparam int ADDR_W  = 4;

	localparam logic [1:0] REG_ANGLE_SHIFT = 2'd0;
	localparam logic [1:0] REG_AMPLITUDE   = 2'd1;
	localparam logic [1:0] REG_SIGMA       = 2'd2;
	localparam logic [1:0] REG_MIN_UNC     = 2'd3;

	localparam logic [31:0]      AMPLITUDE_RST = 32'd512000;
	localparam logic [19:0]      SIGMA_RST     = 20'd125000;
	localparam logic [31:0]      MIN_UNC_RST   = 32'd384;
	localparam logic [16:0]      LOG2E_Q16     = 17'd94548;
	localparam logic [SUM_W-1:0] SUM_MAX       = '1;
	localparam logic [CNT_W-1:0] CNT_MAX       = '1;

	// 2^(-k/16) in Q16, k = 0..16
	localparam logic [16:0] POW2_FRAC [17] = '{
		17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
		17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
		17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
	};

endpackage

// File: rtl/gcsa_if.sv
// ----------------------------------------------------------------------------
// gcsa_pts_if / gcsa_res_if
// Valid/ready channels for input points and emitted sums.
// ----------------------------------------------------------------------------
interface gcsa_pts_if;
	logic                          valid;
	logic                          ready;
	logic signed [gcsa_pkg::ANGLE_W-1:0] angle;
	logic [gcsa_pkg::VALUE_W-1:0]  measured;
	logic [gcsa_pkg::VALUE_W-1:0]  uncertainty;
	logic                          last;

	modport source (output valid, angle, measured, uncertainty, last, input ready);
	modport sink   (input valid, angle, measured, uncertainty, last, output ready);
endinterface

interface gcsa_res_if;
	logic                        valid;
	logic                        ready;
	logic [gcsa_pkg::SUM_W-1:0]  chi_square;
	logic [gcsa_pkg::CNT_W-1:0]  point_count;

	modport source (output valid, chi_square, point_count, input ready);
	modport sink   (input valid, chi_square, point_count, output ready);
endinterface

// File: rtl/gaussian_chi_square_accumulator_top.sv
// ----------------------------------------------------------------------------
// gaussian_chi_square_accumulator_top
// Accumulates squared normalized residuals against a gaussian model.
// Flow: a skipped word goes straight to the final step, a far-tail word skips
// the first division and the exponential; result valid the cycle after the
// final step. Shared radix-2 divider (21 then 32 steps), shared 32x32 multiplier.
// Throughput: one word in flight at a time; a held result stalls the last step.
// Reset: async active low; clears sum, count, control and restores registers.
// ----------------------------------------------------------------------------
module gaussian_chi_square_accumulator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gcsa_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	gcsa_pts_if.sink                      pts,
	gcsa_res_if.source                    res
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_U, ST_M1, ST_M2, ST_D1SET, ST_DIV, ST_M3, ST_P, ST_M4,
		ST_E, ST_M5, ST_F, ST_DIFF, ST_M6, ST_C, ST_FIN
	} state_t;

	state_t state_q;

	logic signed [31:0] shift_q;
	logic [31:0]        amp_q;
	logic [19:0]        sigma_q;
	logic [31:0]        minunc_q;

	logic signed [32:0] x_q;
	logic [31:0]        meas_q, unc_q;
	logic               last_q, used_q, phase_q;
	logic [22:0]        u_q;
	logic [45:0]        usq_q;
	logic [63:0]        prod_q;
	logic [40:0]        rem_q, div_q;
	logic [31:0]        dvd_q, quo_q;
	logic [5:0]         cnt_q;
	logic [5:0]         n_q;
	logic [3:0]         k_q;
	logic [11:0]        w_q;
	logic [16:0]        e_q;
	logic [31:0]        f_q;
	logic [48:0]        c_q;
	logic [47:0]        sum_q;
	logic [15:0]        used_cnt_q;
	logic               res_valid_q;
	logic [47:0]        res_sum_q;
	logic [15:0]        res_cnt_q;

	logic [31:0] mul_a, mul_b;
	logic [19:0] s_eff;
	logic [32:0] u_abs;
	logic [41:0] trial;
	logic        trial_ge;
	logic [21:0] p_val;
	logic [16:0] t_hi, t_lo;
	logic [6:0]  sh;
	logic [63:0] f_rnd;
	logic [31:0] f_full;
	logic [31:0] d_val;
	logic [48:0] sum_room;
	logic [47:0] sum_next;
	logic [15:0] cnt_next;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= '0;
			amp_q    <= gcsa_pkg::AMPLITUDE_RST;
			sigma_q  <= gcsa_pkg::SIGMA_RST;
			minunc_q <= gcsa_pkg::MIN_UNC_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				gcsa_pkg::REG_ANGLE_SHIFT: shift_q  <= pwdata;
				gcsa_pkg::REG_AMPLITUDE:   amp_q    <= pwdata;
				gcsa_pkg::REG_SIGMA:       sigma_q  <= pwdata[19:0];
				gcsa_pkg::REG_MIN_UNC:     minunc_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			gcsa_pkg::REG_ANGLE_SHIFT: prdata = shift_q;
			gcsa_pkg::REG_AMPLITUDE:   prdata = amp_q;
			gcsa_pkg::REG_SIGMA:       prdata = {12'd0, sigma_q};
			gcsa_pkg::REG_MIN_UNC:     prdata = minunc_q;
			default:                   prdata = '0;
		endcase
	end

	assign s_eff = (sigma_q == '0) ? 20'd1 : sigma_q;
	assign u_abs = x_q[32] ? 33'(-x_q) : 33'(x_q);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_M1: begin mul_a = {9'd0, u_q};        mul_b = {9'd0, u_q}; end
			ST_M2: begin mul_a = {12'd0, s_eff};     mul_b = {12'd0, s_eff}; end
			ST_M3: begin mul_a = quo_q;              mul_b = {15'd0, gcsa_pkg::LOG2E_Q16}; end
			ST_M4: begin mul_a = {15'd0, t_hi - t_lo}; mul_b = {20'd0, w_q}; end
			ST_M5: begin mul_a = amp_q;              mul_b = {15'd0, e_q}; end
			ST_M6: begin mul_a = quo_q;              mul_b = quo_q; end
			default: ;
		endcase
	end

	assign t_hi     = gcsa_pkg::POW2_FRAC[k_q];
	assign t_lo     = gcsa_pkg::POW2_FRAC[5'(k_q) + 5'd1];
	assign trial    = {rem_q, dvd_q[31]};
	assign trial_ge = trial >= {1'b0, div_q};
	assign p_val    = 22'((prod_q[37:0] + 38'd32768) >> 16);
	assign sh       = 7'd16 + {1'b0, n_q};
	assign f_rnd    = (prod_q + (64'd1 << (sh - 7'd1))) >> sh;
	assign f_full   = (sh > 7'd62) ? 32'd0 : f_rnd[31:0];
	assign d_val    = (meas_q >= f_q) ? meas_q - f_q : f_q - meas_q;
	assign sum_room = 49'(gcsa_pkg::SUM_MAX) - {1'b0, sum_q};
	assign sum_next = (c_q >= sum_room) ? gcsa_pkg::SUM_MAX : 48'({1'b0, sum_q} + c_q);
	assign cnt_next = (used_q && used_cnt_q != gcsa_pkg::CNT_MAX) ?
		used_cnt_q + 16'd1 : used_cnt_q;

	assign pts.ready       = (state_q == ST_IDLE);
	assign res.valid       = res_valid_q;
	assign res.chi_square  = res_sum_q;
	assign res.point_count = res_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			used_cnt_q  <= '0;
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
			phase_q     <= 1'b0;
		end else begin
			if (res_valid_q && res.ready && !(state_q == ST_FIN && last_q))
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pts.valid) begin
						x_q    <= 33'(pts.angle) + 33'(shift_q);
						meas_q <= pts.measured;
						unc_q  <= pts.uncertainty;
						last_q <= pts.last;
						used_q <= pts.uncertainty >= minunc_q;
						c_q    <= '0;
						state_q <= (pts.uncertainty >= minunc_q) ? ST_U : ST_FIN;
					end
				end
				ST_U: begin
					u_q <= u_abs[22:0];
					if (u_abs >= {10'd0, s_eff, 3'd0}) begin
						f_q     <= '0;
						state_q <= ST_DIFF;
					end else begin
						state_q <= ST_M1;
					end
				end
				ST_M1: begin
					prod_q  <= mul_a * mul_b;
					state_q <= ST_M2;
				end
				ST_M2: begin
					usq_q   <= prod_q[45:0];
					prod_q  <= mul_a * mul_b;
					state_q <= ST_D1SET;
				end
				ST_D1SET: begin
					rem_q   <= usq_q[45:5];
					dvd_q   <= {usq_q[4:0], 27'd0};
					div_q   <= {prod_q[39:0], 1'b0};
					quo_q   <= '0;
					cnt_q   <= 6'd21;
					phase_q <= 1'b0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= trial_ge ? 41'(trial - {1'b0, div_q}) : trial[40:0];
					quo_q <= {quo_q[30:0], trial_ge};
					dvd_q <= {dvd_q[30:0], 1'b0};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1)
						state_q <= phase_q ? ST_M6 : ST_M3;
				end
				ST_M3: begin
					prod_q  <= mul_a * mul_b;
					state_q <= ST_P;
				end
				ST_P: begin
					n_q     <= p_val[21:16];
					k_q     <= p_val[15:12];
					w_q     <= p_val[11:0];
					state_q <= ST_M4;
				end
				ST_M4: begin
					prod_q  <= mul_a * mul_b;
					state_q <= ST_E;
				end
				ST_E: begin
					e_q     <= t_hi - 17'((prod_q[23:0] + 24'd2048) >> 12);
					state_q <= ST_M5;
				end
				ST_M5: begin
					prod_q  <= mul_a * mul_b;
					state_q <= ST_F;
				end
				ST_F: begin
					f_q     <= f_full;
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					if (unc_q == '0) begin
						c_q     <= (d_val != '0) ? '1 : '0;
						state_q <= ST_FIN;
					end else if ({16'd0, d_val[31:16]} >= unc_q) begin
						c_q     <= '1;
						state_q <= ST_FIN;
					end else begin
						rem_q   <= {25'd0, d_val[31:16]};
						dvd_q   <= {d_val[15:0], 16'd0};
						div_q   <= {9'd0, unc_q};
						quo_q   <= '0;
						cnt_q   <= 6'd32;
						phase_q <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_M6: begin
					prod_q  <= mul_a * mul_b;
					state_q <= ST_C;
				end
				ST_C: begin
					c_q     <= {1'b0, 48'((prod_q + 64'd32768) >> 16)};
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q) begin
						sum_q      <= sum_next;
						used_cnt_q <= cnt_next;
						state_q    <= ST_IDLE;
					end else if (!res_valid_q || res.ready) begin
						res_sum_q   <= sum_next;
						res_cnt_q   <= cnt_next;
						res_valid_q <= 1'b1;
						sum_q       <= '0;
						used_cnt_q  <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < div_q))
		else $error("divider remainder not below divisor");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q != '0))
		else $error("divider running with zero step count");

	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_FIN) |=> ($stable(sum_q) && $stable(used_cnt_q)))
		else $error("accumulator changed outside final step");

endmodule
